@@ sv/msr_pkg.sv @@
package msr_pkg;

   // Geometry of the block ring
   localparam int HEADER_BYTES    = 4;
   localparam int MAX_BLOCKS      = 16;
   localparam int MAX_BLOCK_BYTES = 256;
   localparam int STORE_DEPTH     = MAX_BLOCKS * MAX_BLOCK_BYTES;
   localparam int STORE_AW        = $clog2(STORE_DEPTH);
   localparam int FILL_DEPTH      = MAX_BLOCKS;

   // Field and state widths
   localparam int KIND_W  = 2;
   localparam int BLK_W   = 4;
   localparam int BYTE_W  = 8;
   localparam int OFF_W   = 9;
   localparam int CNT_W   = 5;
   localparam int BB_W    = 9;
   localparam int MSG_W   = 13;
   localparam int SER_W   = 8;
   localparam int SLICE_W = 4;
   localparam int SIZE_W  = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 9;

   // Subtract steps that reduce a block-width value below any legal count
   localparam int MOD_STEPS = 2 ** (BLK_W - 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_BYTES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_COUNT = CSR_IDX_W'(1);

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ABORT = 2'd2,
      KIND_TAIL  = 2'd3
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      RES_STORED = 2'd0,
      RES_HEADER = 2'd1,
      RES_DONE   = 2'd2,
      RES_FAILED = 2'd3
   } rsp_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                en;
      logic                we;
      logic [STORE_AW-1:0] addr;
      logic [BYTE_W-1:0]   wdata;
   } store_req_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [BLK_W-1:0]  addr;
      logic [SIZE_W-1:0] wdata;
   } fill_req_type;

   // Reduce a small value modulo the block count (count is at least two)
   function automatic logic [CNT_W-1:0] mod_count(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] r;
      r = v;
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (r >= n) begin
            r = r - n;
         end
      end
      return r;
   endfunction

   // Advance a block index around the ring
   function automatic logic [BLK_W-1:0] inc_ring(input logic [BLK_W-1:0] b,
                                                 input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] nx;
      nx = {1'b0, b} + CNT_W'(1);
      return (nx >= n) ? '0 : BLK_W'(nx);
   endfunction

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = v;
      if (r < CNT_W'(2)) begin
         r = CNT_W'(2);
      end
      if (r > CNT_W'(MAX_BLOCKS)) begin
         r = CNT_W'(MAX_BLOCKS);
      end
      return r;
   endfunction

   function automatic logic [BB_W-1:0] clamp_bytes(input logic [BB_W-1:0] v);
      logic [BB_W-1:0] r;
      r = v;
      if (r < BB_W'(HEADER_BYTES + 1)) begin
         r = BB_W'(HEADER_BYTES + 1);
      end
      if (r > BB_W'(MAX_BLOCK_BYTES)) begin
         r = BB_W'(MAX_BLOCK_BYTES);
      end
      return r;
   endfunction

endpackage

@@ sv/msr_ram.sv @@
module msr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read, new data on a write
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
            rdata_ff     <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/msr_ctl.sv @@
module msr_ctl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [msr_pkg::KIND_W-1:0]      req_kind,
   input  logic [msr_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic [msr_pkg::BLK_W-1:0]       req_tail_index,
   input  logic                            csr_write_enable,
   input  logic [msr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [msr_pkg::CSR_DAT_W-1:0]   csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [msr_pkg::KIND_W-1:0]      rsp_result_kind,
   output logic [msr_pkg::BLK_W-1:0]       rsp_block_index,
   output logic [msr_pkg::BYTE_W-1:0]      rsp_byte_offset,
   output logic [msr_pkg::SER_W-1:0]       rsp_msg_serial,
   output logic [msr_pkg::SLICE_W-1:0]     rsp_frag_index,
   output logic                            rsp_last,
   output msr_pkg::store_req_type          store_req,
   output msr_pkg::fill_req_type           fill_req
);
   import msr_pkg::*;

   localparam logic [OFF_W-1:0] HDR_OFF = OFF_W'(HEADER_BYTES);

   state_type          state_ff, state_in;
   logic [BLK_W-1:0]   head_ff, head_in;
   logic [BLK_W-1:0]   tail_ff, tail_in;
   logic [BLK_W-1:0]   start_ff, start_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [MSG_W-1:0]   count_ff, count_in;
   logic [MSG_W-1:0]   cap_ff, cap_in;
   logic [SER_W-1:0]   serial_ff, serial_in;
   logic               in_msg_ff, in_msg_in;
   logic               failed_ff, failed_in;
   logic [BB_W-1:0]    bb_ff, bb_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         prep_ff, prep_in;

   // Capacity pipeline (payload, recomputed every cycle)
   logic [BLK_W-1:0]   hmod_ff, hmod_in;
   logic [BLK_W-1:0]   tmod_ff, tmod_in;
   logic [MSG_W-1:0]   cap_prep_ff, cap_prep_in;

   logic [BLK_W-1:0]   walk_blk_ff, walk_blk_in;
   logic [SLICE_W-1:0] walk_slice_ff, walk_slice_in;

   logic               out_valid_ff, out_valid_in;
   rsp_kind_type       out_kind_ff, out_kind_in;
   logic [BLK_W-1:0]   out_blk_ff, out_blk_in;
   logic [BYTE_W-1:0]  out_off_ff, out_off_in;
   logic [SER_W-1:0]   out_serial_ff, out_serial_in;
   logic [SLICE_W-1:0] out_slice_ff, out_slice_in;
   logic               out_last_ff, out_last_in;

   logic               slot_free;
   logic               prep_ready;
   logic               req_accept;
   req_kind_type       kind;
   logic [SIZE_W-1:0]  payload;
   logic               opening;
   logic [BLK_W-1:0]   cur_head;
   logic [BLK_W-1:0]   cur_start;
   logic [OFF_W-1:0]   cur_off;
   logic [MSG_W-1:0]   cur_count;
   logic [MSG_W-1:0]   cur_cap;
   logic               cur_failed;
   logic [MSG_W-1:0]   base;
   logic [CNT_W-1:0]   sser_raw;
   logic [SLICE_W-1:0] sser;
   logic [OFF_W-1:0]   off_next;
   logic [BLK_W-1:0]   end_head;
   logic [CNT_W-1:0]   free_raw;
   logic [BLK_W-1:0]   free_blk;
   logic [BLK_W-1:0]   walk_next;

   // Handshake
   assign slot_free  = !out_valid_ff || !rsp_stall;
   assign prep_ready = (prep_ff == 2'd2);
   assign req_stall  = (state_ff != ST_IDLE) || !slot_free || (!in_msg_ff && !prep_ready);
   assign req_accept = req_valid && !req_stall;
   assign kind       = req_kind_type'(req_kind);
   assign payload    = SIZE_W'(bb_ff - BB_W'(HEADER_BYTES));

   // Message start values when no message is open
   assign opening    = !in_msg_ff;
   assign cur_head   = opening ? hmod_ff : head_ff;
   assign cur_start  = opening ? hmod_ff : start_ff;
   assign cur_off    = opening ? HDR_OFF : off_ff;
   assign cur_count  = opening ? '0 : count_ff;
   assign cur_cap    = opening ? cap_prep_ff : cap_ff;
   assign cur_failed = opening ? 1'b0 : failed_ff;

   // Store address and slice of the byte
   assign base     = {{BB_W{1'b0}}, cur_head} * {{BLK_W{1'b0}}, bb_ff};
   assign sser_raw = {1'b0, cur_head} + cnt_ff - {1'b0, cur_start};
   assign sser     = SLICE_W'((sser_raw >= cnt_ff) ? sser_raw - cnt_ff : sser_raw);
   assign off_next = cur_off + OFF_W'(1);
   assign end_head = (cur_off > HDR_OFF) ? inc_ring(cur_head, cnt_ff) : cur_head;
   assign walk_next = inc_ring(walk_blk_ff, cnt_ff);

   // Capacity pipeline: reduce head and tail, then free blocks times payload
   assign free_raw = cnt_ff + {1'b0, hmod_ff} - {1'b0, tmod_ff} - CNT_W'(1);
   assign free_blk = BLK_W'((free_raw >= cnt_ff) ? free_raw - cnt_ff : free_raw);

   always_comb begin
      hmod_in     = BLK_W'(mod_count({1'b0, head_ff}, cnt_ff));
      tmod_in     = BLK_W'(mod_count({1'b0, tail_ff}, cnt_ff));
      cap_prep_in = {{(MSG_W-BLK_W){1'b0}}, free_blk} * {{(MSG_W-SIZE_W){1'b0}}, payload};
      if (req_accept || csr_write_enable || state_ff != ST_IDLE) begin
         prep_in = 2'd0;
      end else if (prep_ready) begin
         prep_in = prep_ff;
      end else begin
         prep_in = prep_ff + 2'd1;
      end
   end

   // Next state, message bookkeeping and result loading
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      start_in      = start_ff;
      off_in        = off_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      serial_in     = serial_ff;
      in_msg_in     = in_msg_ff;
      failed_in     = failed_ff;
      bb_in         = bb_ff;
      cnt_in        = cnt_ff;
      walk_blk_in   = walk_blk_ff;
      walk_slice_in = walk_slice_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_kind_in   = out_kind_ff;
      out_blk_in    = out_blk_ff;
      out_off_in    = out_off_ff;
      out_serial_in = out_serial_ff;
      out_slice_in  = out_slice_ff;
      out_last_in   = out_last_ff;
      store_req       = '0;
      store_req.addr  = STORE_AW'(base + {{(MSG_W-OFF_W){1'b0}}, cur_off});
      store_req.wdata = req_data_byte;
      fill_req        = '0;
      fill_req.addr   = cur_head;
      fill_req.wdata  = SIZE_W'(cur_off - OFF_W'(HEADER_BYTES - 1));

      // Take register writes outside a message only
      if (csr_write_enable && !in_msg_ff) begin
         case (csr_index)
            REG_BLOCK_BYTES: bb_in  = clamp_bytes(csr_write_data);
            REG_BLOCK_COUNT: cnt_in = clamp_count(csr_write_data[CNT_W-1:0]);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (kind == KIND_TAIL) begin
                  tail_in = req_tail_index;
               end else begin
                  // Open the message if needed
                  head_in   = cur_head;
                  start_in  = cur_start;
                  off_in    = cur_off;
                  count_in  = cur_count;
                  cap_in    = cur_cap;
                  failed_in = cur_failed;
                  in_msg_in = 1'b1;
                  out_serial_in = serial_ff;
                  out_off_in    = '0;
                  out_last_in   = 1'b1;
                  if (kind == KIND_BYTE) begin
                     if (cur_failed) begin
                        // drop silently
                     end else if ((cur_count + MSG_W'(1)) > cur_cap) begin
                        failed_in = 1'b1;
                        head_in   = cur_start;
                     end else begin
                        store_req.en   = 1'b1;
                        store_req.we   = 1'b1;
                        fill_req.en    = 1'b1;
                        fill_req.we    = 1'b1;
                        out_valid_in   = 1'b1;
                        out_kind_in    = RES_STORED;
                        out_blk_in     = cur_head;
                        out_off_in     = BYTE_W'(cur_off);
                        out_slice_in   = sser;
                        count_in       = cur_count + MSG_W'(1);
                        if (off_next >= bb_ff) begin
                           off_in  = HDR_OFF;
                           head_in = inc_ring(cur_head, cnt_ff);
                        end else begin
                           off_in = off_next;
                        end
                     end
                  end else if (kind == KIND_ABORT || cur_failed) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = RES_FAILED;
                     out_blk_in   = cur_start;
                     out_slice_in = '0;
                     head_in      = cur_start;
                     in_msg_in    = 1'b0;
                     failed_in    = 1'b0;
                     off_in       = HDR_OFF;
                  end else begin
                     // Commit a partly filled block, then walk the headers
                     head_in = end_head;
                     if (end_head == cur_start) begin
                        out_valid_in = 1'b1;
                        out_kind_in  = RES_DONE;
                        out_blk_in   = end_head;
                        out_slice_in = '0;
                        serial_in    = serial_ff + SER_W'(1);
                        in_msg_in    = 1'b0;
                        off_in       = HDR_OFF;
                     end else begin
                        walk_blk_in   = cur_start;
                        walk_slice_in = '0;
                        state_in      = ST_WALK;
                     end
                  end
               end
            end
         end
         ST_WALK: begin
            if (slot_free) begin
               fill_req.en   = 1'b1;
               fill_req.addr = walk_blk_ff;
               out_valid_in  = 1'b1;
               out_kind_in   = RES_HEADER;
               out_blk_in    = walk_blk_ff;
               out_off_in    = '0;
               out_serial_in = serial_ff;
               out_slice_in  = walk_slice_ff;
               out_last_in   = 1'b0;
               walk_blk_in   = walk_next;
               walk_slice_in = walk_slice_ff + SLICE_W'(1);
               if (walk_next == head_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = RES_DONE;
               out_blk_in    = head_ff;
               out_off_in    = '0;
               out_serial_in = serial_ff;
               out_slice_in  = walk_slice_ff;
               out_last_in   = 1'b1;
               serial_in     = serial_ff + SER_W'(1);
               in_msg_in     = 1'b0;
               off_in        = HDR_OFF;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         start_ff     <= '0;
         off_ff       <= HDR_OFF;
         count_ff     <= '0;
         cap_ff       <= '0;
         serial_ff    <= '0;
         in_msg_ff    <= 1'b0;
         failed_ff    <= 1'b0;
         bb_ff        <= BB_W'(MAX_BLOCK_BYTES);
         cnt_ff       <= CNT_W'(MAX_BLOCKS);
         prep_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         start_ff     <= start_in;
         off_ff       <= off_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         serial_ff    <= serial_in;
         in_msg_ff    <= in_msg_in;
         failed_ff    <= failed_in;
         bb_ff        <= bb_in;
         cnt_ff       <= cnt_in;
         prep_ff      <= prep_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      hmod_ff       <= hmod_in;
      tmod_ff       <= tmod_in;
      cap_prep_ff   <= cap_prep_in;
      walk_blk_ff   <= walk_blk_in;
      walk_slice_ff <= walk_slice_in;
      out_kind_ff   <= out_kind_in;
      out_blk_ff    <= out_blk_in;
      out_off_ff    <= out_off_in;
      out_serial_ff <= out_serial_in;
      out_slice_ff  <= out_slice_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_block_index = out_blk_ff;
   assign rsp_byte_offset = out_off_ff;
   assign rsp_msg_serial  = out_serial_ff;
   assign rsp_frag_index  = out_slice_ff;
   assign rsp_last        = out_last_ff;

   // Header walk only runs inside an open message
   a_walk_in_msg: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> in_msg_ff)
      else $error("header walk outside a message");

   // Head stays inside the ring while a message is open
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      in_msg_ff |-> ({1'b0, head_ff} < cnt_ff && {1'b0, start_ff} < cnt_ff))
      else $error("head beyond block count");

   // Write offset stays between header area and block end
   a_off_range: assert property (@(posedge clock) disable iff (reset)
      in_msg_ff |-> (off_ff >= HDR_OFF && off_ff < bb_ff))
      else $error("offset outside payload area");

endmodule

@@ sv/message_slicer_ring_top.sv @@
// Byte word: result in the cycle after acceptance. Unless the receiver stalls, a message
// takes one byte per cycle, and its end reads one header per cycle from the block fill
// memory, then gives one done word. With no message open, an item waits after any item,
// register write or message close until the head/tail reduction and capacity multiply
// pipeline refills. Reset is synchronous; block store and fill memory are not cleared.
module message_slicer_ring_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [msr_pkg::KIND_W-1:0]      req_kind,
   input  logic [msr_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic [msr_pkg::BLK_W-1:0]       req_tail_index,
   input  logic                            csr_write_enable,
   input  logic [msr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [msr_pkg::CSR_DAT_W-1:0]   csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [msr_pkg::KIND_W-1:0]      rsp_result_kind,
   output logic [msr_pkg::BLK_W-1:0]       rsp_block_index,
   output logic [msr_pkg::BYTE_W-1:0]      rsp_byte_offset,
   output logic [msr_pkg::BYTE_W-1:0]      rsp_stored_byte,
   output logic [msr_pkg::SER_W-1:0]       rsp_msg_serial,
   output logic [msr_pkg::SLICE_W-1:0]     rsp_frag_index,
   output logic [msr_pkg::SIZE_W-1:0]      rsp_frag_size,
   output logic                            rsp_last
);
   import msr_pkg::*;

   store_req_type     store_req;
   fill_req_type      fill_req;
   logic [BYTE_W-1:0] store_q;
   logic [SIZE_W-1:0] fill_q;

   msr_ctl u_ctl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_data_byte    (req_data_byte),
      .req_tail_index   (req_tail_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_block_index  (rsp_block_index),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_msg_serial   (rsp_msg_serial),
      .rsp_frag_index   (rsp_frag_index),
      .rsp_last         (rsp_last),
      .store_req        (store_req),
      .fill_req         (fill_req)
   );

   // Block ring contents
   msr_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock (clock),
      .en    (store_req.en),
      .we    (store_req.we),
      .addr  (store_req.addr),
      .wdata (store_req.wdata),
      .rdata (store_q)
   );

   // Payload fill of each block, read back for the header words
   msr_ram #(.WIDTH(SIZE_W), .DEPTH(FILL_DEPTH)) u_fill (
      .clock (clock),
      .en    (fill_req.en),
      .we    (fill_req.we),
      .addr  (fill_req.addr),
      .wdata (fill_req.wdata),
      .rdata (fill_q)
   );

   // Show memory data only on the word kinds that carry it
   assign rsp_stored_byte =
      (rsp_result_kind == KIND_W'(RES_STORED)) ? store_q : '0;
   assign rsp_frag_size =
      (rsp_result_kind == KIND_W'(RES_HEADER)) ? fill_q : '0;

endmodule

@@ tb/sv/message_slicer_ring_top_tb.sv @@
`timescale 1ns / 100ps

module message_slicer_ring_top_tb;
   import msr_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 340;
   localparam int MAX_HEADERS   = 15;
   localparam int TIMEOUT_NS    = 5_000_000;

   // One result word as the ring reports it
   typedef struct {
      rsp_kind_type        kind;
      logic [BLK_W-1:0]    blk;
      logic [BYTE_W-1:0]   offset;
      logic [BYTE_W-1:0]   data;
      logic [SER_W-1:0]    serial;
      logic [SLICE_W-1:0]  slice;
      logic [SIZE_W-1:0]   payload_size;
      logic                last;
   } ring_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [BYTE_W-1:0]     req_data_byte = '0;
   logic [BLK_W-1:0]      req_tail_index = '0;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DAT_W-1:0]  csr_write_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_W-1:0]     rsp_result_kind;
   logic [BLK_W-1:0]      rsp_block_index;
   logic [BYTE_W-1:0]     rsp_byte_offset;
   logic [BYTE_W-1:0]     rsp_stored_byte;
   logic [SER_W-1:0]      rsp_msg_serial;
   logic [SLICE_W-1:0]    rsp_frag_index;
   logic [SIZE_W-1:0]     rsp_frag_size;
   logic                  rsp_last;

   ring_word_type expected_words[$];
   int errors = 0;
   int items_sent = 0;
   int burst_left = 0;

   // Shadow copy of the ring state and its registers
   logic [BB_W-1:0]  p_block_bytes = BB_W'(256);
   logic [CNT_W-1:0] p_block_count = CNT_W'(16);
   int p_head = 0;
   int p_tail = 0;
   int p_start = 0;
   int p_offset = HEADER_BYTES;
   int p_count = 0;
   int p_capacity = 0;
   int p_serial = 0;
   bit p_open = 1'b0;
   bit p_failed = 1'b0;

   int stall_mode = 0;
   int stall_left = 0;

   message_slicer_ring_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_data_byte    (req_data_byte),
      .req_tail_index   (req_tail_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_block_index  (rsp_block_index),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_stored_byte  (rsp_stored_byte),
      .rsp_msg_serial   (rsp_msg_serial),
      .rsp_frag_index   (rsp_frag_index),
      .rsp_frag_size    (rsp_frag_size),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamped register values as the ring uses them
   function automatic int ring_count();
      int c;
      c = p_block_count;
      if (c < 2) c = 2;
      if (c > MAX_BLOCKS) c = MAX_BLOCKS;
      return c;
   endfunction

   function automatic int ring_bytes();
      int b;
      b = p_block_bytes;
      if (b < HEADER_BYTES + 1) b = HEADER_BYTES + 1;
      if (b > MAX_BLOCK_BYTES) b = MAX_BLOCK_BYTES;
      return b;
   endfunction

   // Payload room between the head and the consumer tail
   function automatic int ring_capacity();
      int cnt, h, t;
      cnt = ring_count();
      h = p_head % cnt;
      t = p_tail % cnt;
      return ((cnt + h - t - 1) % cnt) * (ring_bytes() - HEADER_BYTES);
   endfunction

   function automatic void push_word(rsp_kind_type kind, int blk, int offset, int data,
                                     int slice, int payload_size, logic last);
      ring_word_type w;
      w.kind         = kind;
      w.blk          = BLK_W'(blk);
      w.offset       = BYTE_W'(offset);
      w.data         = BYTE_W'(data);
      w.serial       = SER_W'(p_serial);
      w.slice        = SLICE_W'(slice);
      w.payload_size = SIZE_W'(payload_size);
      w.last         = last;
      expected_words.push_back(w);
   endfunction

   // Advance the shadow ring by one input word and queue the words it causes
   function automatic void predict_item(req_kind_type kind, logic [BYTE_W-1:0] data,
                                        logic [BLK_W-1:0] tail);
      int cnt, bb, remaining, blk, slice, sz;
      cnt = ring_count();
      bb  = ring_bytes();
      if (kind == KIND_TAIL) begin
         p_tail = tail;
      end else begin
         // open a message and latch its capacity
         if (!p_open) begin
            p_capacity = ring_capacity();
            p_head     = p_head % cnt;
            p_start    = p_head;
            p_offset   = HEADER_BYTES;
            p_count    = 0;
            p_open     = 1'b1;
            p_failed   = 1'b0;
         end
         if (kind == KIND_BYTE) begin
            if (!p_failed && p_count + 1 > p_capacity) begin
               // overflow: roll the head back, drop the rest
               p_failed = 1'b1;
               p_head   = p_start;
            end else if (!p_failed) begin
               push_word(RES_STORED, p_head, p_offset, data,
                         (p_head + cnt - p_start) % cnt, 0, 1'b1);
               p_count++;
               p_offset++;
               if (p_offset >= bb) begin
                  p_head   = (p_head + 1) % cnt;
                  p_offset = HEADER_BYTES;
               end
            end
         end else if (kind == KIND_ABORT || p_failed) begin
            p_head = p_start;
            push_word(RES_FAILED, p_head, 0, 0, 0, 0, 1'b1);
            p_open   = 1'b0;
            p_failed = 1'b0;
            p_offset = HEADER_BYTES;
         end else begin
            // commit a partial block, then one header per block and a done word
            if (p_offset > HEADER_BYTES) p_head = (p_head + 1) % cnt;
            blk       = p_start;
            remaining = p_count;
            slice     = 0;
            while (blk != p_head && slice < MAX_HEADERS) begin
               sz = (remaining > bb - HEADER_BYTES) ? bb - HEADER_BYTES : remaining;
               push_word(RES_HEADER, blk, 0, 0, slice, sz, 1'b0);
               remaining -= sz;
               slice++;
               blk = (blk + 1) % cnt;
            end
            push_word(RES_DONE, p_head, 0, 0, slice, 0, 1'b1);
            p_serial = (p_serial + 1) & 255;
            p_open   = 1'b0;
            p_offset = HEADER_BYTES;
         end
      end
   endfunction

   // Drive one word; sender works in bursts with random gaps
   task automatic send_word(req_kind_type kind, logic [BYTE_W-1:0] data,
                            logic [BLK_W-1:0] tail);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_data_byte  <= data;
      req_tail_index <= tail;
      predict_item(kind, data, tail);
      items_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Random bytes, an occasional tail update inside, then end or abort
   task automatic send_message(int len, req_kind_type finish);
      for (int i = 0; i < len; i++) begin
         send_word(KIND_BYTE, BYTE_W'($urandom_range(0, 255)), BLK_W'($urandom_range(0, 15)));
         if ($urandom_range(0, 29) == 0) begin
            send_word(KIND_TAIL, BYTE_W'($urandom_range(0, 255)),
                      BLK_W'($urandom_range(0, 15)));
         end
      end
      send_word(finish, BYTE_W'($urandom_range(0, 255)), BLK_W'($urandom_range(0, 15)));
   endtask

   // Close any open message, hold the sender until every word is back
   task automatic settle_ring();
      if (p_open) begin
         send_word(KIND_END, BYTE_W'($urandom_range(0, 255)), BLK_W'($urandom_range(0, 15)));
      end
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (!p_open) begin
         if (idx == REG_BLOCK_BYTES) p_block_bytes = value;
         else p_block_count = value[CNT_W-1:0];
      end
      @(posedge clock);
   endtask

   task automatic configure_ring(logic [CSR_DAT_W-1:0] bb, logic [CSR_DAT_W-1:0] count);
      settle_ring();
      write_register(REG_BLOCK_BYTES, bb);
      write_register(REG_BLOCK_COUNT, count);
   endtask

   // Reset geometry: empty message, idle abort, short message, tail update
   task automatic test_message_basics();
      send_word(KIND_END, 8'h00, 4'h0);
      send_word(KIND_ABORT, 8'hFF, 4'hF);
      send_word(KIND_BYTE, 8'h00, 4'hF);
      send_word(KIND_BYTE, 8'hFF, 4'h0);
      send_word(KIND_END, 8'h5A, 4'h5);
      send_word(KIND_TAIL, 8'hA5, 4'hF);
   endtask

   // Out-of-range register values, tail beyond count, zero capacity
   task automatic test_register_clamp();
      configure_ring('0, '0);
      send_message(1, KIND_END);
      configure_ring('1, '1);
      send_message(1, KIND_ABORT);
      send_word(KIND_TAIL, 8'h3C, 4'h0);
   endtask

   // Overflow with a tail update mid-message, full ring, abort inside a message
   task automatic test_ring_overflow();
      configure_ring(CSR_DAT_W'(HEADER_BYTES + 1), CSR_DAT_W'(4));
      send_word(KIND_BYTE, 8'h11, 4'h2);
      send_word(KIND_TAIL, 8'h22, 4'h1);
      send_word(KIND_BYTE, 8'h33, 4'h4);
      send_word(KIND_BYTE, 8'h44, 4'h8);
      send_word(KIND_BYTE, 8'h55, 4'h3);
      send_word(KIND_BYTE, 8'h66, 4'h7);
      send_word(KIND_END, 8'h77, 4'hC);
      send_word(KIND_TAIL, 8'h88, 4'h0);
      send_message(3, KIND_END);
      send_word(KIND_TAIL, 8'h99, 4'h3);
      send_message(1, KIND_ABORT);
   endtask

   // Shrink the ring below the current head
   task automatic test_head_wrap();
      configure_ring(CSR_DAT_W'(HEADER_BYTES + 1), CSR_DAT_W'(2));
      send_message(1, KIND_END);
   endtask

   // Phases of random geometry, mostly well-formed messages plus noise
   task automatic test_random_traffic();
      int start_items, cap, len, lim, r;
      logic [CSR_DAT_W-1:0] bb_pick, count_pick;
      start_items = items_sent;
      while (items_sent - start_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       bb_pick = CSR_DAT_W'(HEADER_BYTES + 1);
            1:       bb_pick = CSR_DAT_W'(MAX_BLOCK_BYTES);
            2:       bb_pick = CSR_DAT_W'($urandom_range(0, 511));
            default: bb_pick = CSR_DAT_W'($urandom_range(HEADER_BYTES + 1, 24));
         endcase
         case ($urandom_range(0, 5))
            0:       count_pick = CSR_DAT_W'(2);
            1:       count_pick = CSR_DAT_W'(MAX_BLOCKS);
            2:       count_pick = CSR_DAT_W'($urandom_range(0, 511));
            default: count_pick = CSR_DAT_W'($urandom_range(2, MAX_BLOCKS));
         endcase
         configure_ring(bb_pick, count_pick);
         repeat ($urandom_range(3, 8)) begin
            // release consumed blocks half of the time
            r = $urandom_range(0, 9);
            if (r < 5) begin
               send_word(KIND_TAIL, BYTE_W'($urandom_range(0, 255)), BLK_W'(p_head));
            end else if (r == 5) begin
               send_word(KIND_TAIL, BYTE_W'($urandom_range(0, 255)),
                         BLK_W'($urandom_range(0, 15)));
            end
            if ($urandom_range(0, 14) == 0) begin
               send_word(req_kind_type'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                         BLK_W'($urandom_range(0, 15)));
            end
            cap = p_open ? p_capacity - p_count : ring_capacity();
            lim = (cap < 1) ? 1 : ((cap > 24) ? 24 : cap);
            r = $urandom_range(0, 19);
            if (r < 3 && cap <= 40) len = cap;
            else if (r < 5 && cap <= 40) len = cap + $urandom_range(1, 3);
            else if (r < 6) len = 0;
            else len = $urandom_range(1, lim);
            send_message(len, ($urandom_range(0, 6) == 0) ? KIND_ABORT : KIND_END);
         end
      end
   endtask

   // Receiver stall pattern: free, sparse and heavy stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(8, 48);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 2) == 0);
         default: rsp_stall <= ($urandom_range(0, 5) != 0);
      endcase
   end

   task automatic check_field(string name, int unsigned expv, int unsigned actv);
      if (expv != actv) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, name, expv, actv);
      end
   endtask

   // Compare each accepted word with the oldest expectation
   always @(posedge clock) begin : check_words
      ring_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none actual kind %0d block %0d",
                     $time, rsp_result_kind, rsp_block_index);
         end else begin
            want = expected_words.pop_front();
            check_field("result_kind", want.kind, rsp_result_kind);
            check_field("block_index", want.blk, rsp_block_index);
            check_field("byte_offset", want.offset, rsp_byte_offset);
            check_field("stored_byte", want.data, rsp_stored_byte);
            check_field("msg_serial", want.serial, rsp_msg_serial);
            check_field("frag_index", want.slice, rsp_frag_index);
            check_field("frag_size", want.payload_size, rsp_frag_size);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_message_basics();
      test_register_clamp();
      test_ring_overflow();
      test_head_wrap();
      test_random_traffic();
      settle_ring();
      repeat (SETTLE_CYCLES * 4) @(posedge clock);
      if (errors == 0) begin
         $display("message_slicer_ring_top test passed");
      end else begin
         $display("message_slicer_ring_top test failed");
      end
      $finish;
   end

   // Hard stop if the ring hangs
   initial begin
      #(TIMEOUT_NS);
      $display("message_slicer_ring_top test failed");
      $finish;
   end

endmodule
